[rtl/core/trb_pkg.sv]
package trb_pkg;

    localparam int DEPTH     = 16;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int TIME_W    = 48;
    localparam int HANDLE_W  = 16;
    localparam int AGE_W     = 4;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PURGE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_INC  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_OLD  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_ENTRY = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE  = 2'd1;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [HANDLE_W-1:0] payload_handle;
        logic [TIME_W-1:0]   item_time;
        logic [TIME_W-1:0]   current_time;
        logic [AGE_W-1:0]    age_index;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] payload_out;
        logic [CNT_W-1:0]    stored_count;
    } out_item_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   stamp;
    } entry_t;

    // operands of the shared subtractor: result = a - b
    typedef struct packed {
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
    } sub_req_t;

    typedef struct packed {
        logic              borrow;
        logic [TIME_W-1:0] diff;
    } sub_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_CMP,
        S_ADD_AGE,
        S_ADD_LIM,
        S_ADD_EVAL,
        S_PRUNE_CHK,
        S_RD_CHK,
        S_FETCH,
        S_CHK_AGE,
        S_CHK_LIM,
        S_CHK_EVAL,
        S_DONE
    } state_t;

endpackage

[rtl/core/timestamped_ring_buffer_with_expiry_top.sv]
// Channel | Ports                     | Moves
// --------+---------------------------+-----------------------------------------
// input   | s_valid s_ready s_data    | command item (add / read / purge)
// result  | m_valid m_ready m_data    | status, handle, entry count per item
// config  | cfg_wr_en cfg_index       | register write, no wait
//         | cfg_wdata                 |
//
// One item at a time. A prune inspects entries from the oldest and drops each
// expired one (expiry on); the one shared 48-bit subtractor is used twice per
// age check.
// Synchronous reset empties the ring and restores the registers; s_ready is low.
// A stalled result holds in the output register; the next item waits in done.
module timestamped_ring_buffer_with_expiry_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  trb_pkg::in_item_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output trb_pkg::out_item_t              m_data,
    input  logic                            cfg_wr_en,
    input  logic [trb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [trb_pkg::CFG_W-1:0]       cfg_wdata
);

    localparam int CNT_W  = trb_pkg::CNT_W;
    localparam int ADDR_W = trb_pkg::ADDR_W;
    localparam int TIME_W = trb_pkg::TIME_W;

    trb_pkg::state_t    state_reg, state_next;
    trb_pkg::in_item_t  item_reg, item_next;
    trb_pkg::out_item_t m_data_reg, m_data_next;
    logic               m_valid_reg, m_valid_next;

    logic [CNT_W-1:0]   cap_reg, cap_next;
    logic [TIME_W-1:0]  max_age_reg, max_age_next;
    logic [ADDR_W-1:0]  ws_reg, ws_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [TIME_W-1:0]  last_reg, last_next;
    logic               have_reg, have_next;
    logic               b1_reg, b1_next;
    logic [trb_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [trb_pkg::HANDLE_W-1:0] pay_reg, pay_next;

    trb_pkg::sub_req_t  sub_req;
    trb_pkg::sub_rsp_t  sub_rsp;
    logic               st_wr_en;
    trb_pkg::entry_t    st_wr_data;
    trb_pkg::entry_t    st_rd_data;
    logic [ADDR_W-1:0]  st_rd_addr;

    logic               expired;
    logic               age_ok;
    logic               is_read;
    logic               out_free;
    logic [CNT_W-1:0]   cap_wr;

    // slot that lies "back" places behind the write slot, back in 1..cap
    function automatic logic [ADDR_W-1:0] slot_at(
        input logic [ADDR_W-1:0] ws,
        input logic [CNT_W-1:0]  cap,
        input logic [CNT_W-1:0]  back
    );
        logic [CNT_W:0] s;
        s = {{(CNT_W + 1 - ADDR_W){1'b0}}, ws} + {1'b0, cap} - {1'b0, back};
        if (s >= {1'b0, cap}) begin
            s = s - {1'b0, cap};
        end
        return s[ADDR_W-1:0];
    endfunction

    trb_sub u_sub (
        .aclk (aclk),
        .req  (sub_req),
        .rsp  (sub_rsp)
    );

    trb_store u_store (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (ws_reg),
        .wr_data (st_wr_data),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    // expired: now >= stamp (first subtract no borrow) and age > max_age
    // (second subtract max_age - age borrows), with expiry enabled
    assign expired  = (max_age_reg != '0) && !b1_reg && sub_rsp.borrow;
    assign age_ok   = {1'b0, item_reg.age_index} < count_reg;
    assign is_read  = item_reg.cmd == trb_pkg::CMD_READ;
    assign out_free = !m_valid_reg || m_ready;

    // clamp a capacity write into 1..DEPTH
    always_comb begin
        if (cfg_wdata == '0) begin
            cap_wr = CNT_W'(1);
        end else if (cfg_wdata > trb_pkg::CFG_W'(trb_pkg::DEPTH)) begin
            cap_wr = CNT_W'(trb_pkg::DEPTH);
        end else begin
            cap_wr = cfg_wdata[CNT_W-1:0];
        end
    end

    // read address: the entry asked for on a read, the oldest one otherwise
    assign st_rd_addr = is_read
        ? slot_at(ws_reg, cap_reg, {1'b0, item_reg.age_index} + CNT_W'(1))
        : slot_at(ws_reg, cap_reg, count_reg);

    assign st_wr_data.handle = item_reg.payload_handle;
    assign st_wr_data.stamp  = item_reg.item_time;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            trb_pkg::S_IDLE: begin
                if (s_valid) begin
                    unique case (s_data.cmd)
                        trb_pkg::CMD_ADD:   state_next = trb_pkg::S_ADD_CMP;
                        trb_pkg::CMD_READ:  state_next = trb_pkg::S_RD_CHK;
                        trb_pkg::CMD_PURGE: state_next = trb_pkg::S_PRUNE_CHK;
                        default:            state_next = trb_pkg::S_DONE;
                    endcase
                end
            end
            trb_pkg::S_ADD_CMP: state_next = trb_pkg::S_ADD_AGE;
            trb_pkg::S_ADD_AGE: begin
                if (have_reg && !sub_rsp.borrow) begin
                    state_next = trb_pkg::S_DONE;
                end else begin
                    state_next = trb_pkg::S_ADD_LIM;
                end
            end
            trb_pkg::S_ADD_LIM: state_next = trb_pkg::S_ADD_EVAL;
            trb_pkg::S_ADD_EVAL: begin
                state_next = expired ? trb_pkg::S_DONE : trb_pkg::S_PRUNE_CHK;
            end
            trb_pkg::S_PRUNE_CHK: begin
                if (max_age_reg == '0 || count_reg == '0) begin
                    state_next = trb_pkg::S_DONE;
                end else begin
                    state_next = trb_pkg::S_FETCH;
                end
            end
            trb_pkg::S_RD_CHK: begin
                state_next = age_ok ? trb_pkg::S_FETCH : trb_pkg::S_DONE;
            end
            trb_pkg::S_FETCH:   state_next = trb_pkg::S_CHK_AGE;
            trb_pkg::S_CHK_AGE: state_next = trb_pkg::S_CHK_LIM;
            trb_pkg::S_CHK_LIM: state_next = trb_pkg::S_CHK_EVAL;
            trb_pkg::S_CHK_EVAL: begin
                if (!is_read && expired) begin
                    state_next = trb_pkg::S_PRUNE_CHK;
                end else begin
                    state_next = trb_pkg::S_DONE;
                end
            end
            trb_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = trb_pkg::S_IDLE;
                end
            end
            default: state_next = trb_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        item_next    = item_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cap_next     = cap_reg;
        max_age_next = max_age_reg;
        ws_next      = ws_reg;
        count_next   = count_reg;
        last_next    = last_reg;
        have_next    = have_reg;
        b1_next      = b1_reg;
        status_next  = status_reg;
        pay_next     = pay_reg;
        st_wr_en     = 1'b0;
        sub_req.a    = item_reg.current_time;
        sub_req.b    = st_rd_data.stamp;

        unique case (state_reg)
            trb_pkg::S_IDLE: begin
                if (s_valid) begin
                    item_next   = s_data;
                    status_next = trb_pkg::ST_OK;
                    pay_next    = '0;
                end
            end
            trb_pkg::S_ADD_CMP: begin
                // last - item: no borrow means the stamp does not increase
                sub_req.a = last_reg;
                sub_req.b = item_reg.item_time;
            end
            trb_pkg::S_ADD_AGE: begin
                sub_req.a = item_reg.current_time;
                sub_req.b = item_reg.item_time;
                if (have_reg && !sub_rsp.borrow) begin
                    status_next = trb_pkg::ST_NOT_INC;
                end
            end
            trb_pkg::S_ADD_LIM, trb_pkg::S_CHK_LIM: begin
                b1_next   = sub_rsp.borrow;
                sub_req.a = max_age_reg;
                sub_req.b = sub_rsp.diff;
            end
            trb_pkg::S_ADD_EVAL: begin
                if (expired) begin
                    status_next = trb_pkg::ST_TOO_OLD;
                end else begin
                    // commit at the write slot, overwrite the oldest when full
                    st_wr_en  = 1'b1;
                    last_next = item_reg.item_time;
                    have_next = 1'b1;
                    if ({1'b0, ws_reg} + CNT_W'(1) == cap_reg) begin
                        ws_next = '0;
                    end else begin
                        ws_next = ws_reg + ADDR_W'(1);
                    end
                    if (count_reg < cap_reg) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            trb_pkg::S_RD_CHK: begin
                if (!age_ok) begin
                    status_next = trb_pkg::ST_NO_ENTRY;
                end
            end
            trb_pkg::S_CHK_EVAL: begin
                if (is_read) begin
                    if (expired) begin
                        status_next = trb_pkg::ST_NO_ENTRY;
                    end else begin
                        pay_next = st_rd_data.handle;
                    end
                end else if (expired) begin
                    // drop the oldest entry and look at the next one
                    count_next = count_reg - CNT_W'(1);
                end
            end
            trb_pkg::S_DONE: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.status       = status_reg;
                    m_data_next.payload_out  = pay_reg;
                    m_data_next.stored_count = count_reg;
                end
            end
            default: begin
            end
        endcase

        // the user must write configuration only while idle; the block does not enforce it
        if (cfg_wr_en) begin
            unique case (cfg_index)
                trb_pkg::CFG_CAPACITY: begin
                    cap_next   = cap_wr;
                    ws_next    = '0;
                    count_next = '0;
                    last_next  = '0;
                    have_next  = 1'b0;
                end
                trb_pkg::CFG_MAX_AGE: begin
                    max_age_next = cfg_wdata[TIME_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= trb_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
            cap_reg     <= CNT_W'(trb_pkg::DEPTH);
            max_age_reg <= '0;
            ws_reg      <= '0;
            count_reg   <= '0;
            last_reg    <= '0;
            have_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cap_reg     <= cap_next;
            max_age_reg <= max_age_next;
            ws_reg      <= ws_next;
            count_reg   <= count_next;
            last_reg    <= last_next;
            have_reg    <= have_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        m_data_reg <= m_data_next;
        b1_reg     <= b1_next;
        status_reg <= status_next;
        pay_reg    <= pay_next;
    end

    // hold off input while reset is applied
    assign s_ready = aresetn && (state_reg == trb_pkg::S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/core/trb_sub.sv]
module trb_sub (
    input  logic              aclk,
    input  trb_pkg::sub_req_t req,
    output trb_pkg::sub_rsp_t rsp
);

    logic [trb_pkg::TIME_W:0] result_reg;

    // one wide subtract per cycle, borrow in the top bit
    always_ff @(posedge aclk) begin
        result_reg <= {1'b0, req.a} - {1'b0, req.b};
    end

    assign rsp.borrow = result_reg[trb_pkg::TIME_W];
    assign rsp.diff   = result_reg[trb_pkg::TIME_W-1:0];

endmodule

[rtl/core/trb_store.sv]
module trb_store (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [trb_pkg::ADDR_W-1:0]   wr_addr,
    input  trb_pkg::entry_t              wr_data,
    input  logic [trb_pkg::ADDR_W-1:0]   rd_addr,
    output trb_pkg::entry_t              rd_data
);

    trb_pkg::entry_t mem [trb_pkg::DEPTH];
    trb_pkg::entry_t rd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    assign rd_data = rd_reg;

endmodule

[bench/timestamped_ring_buffer_with_expiry_top_tb.sv]
`timescale 1ns / 1ps

import trb_pkg::*;

// Mirror of the ring: holds the entries, the configuration and the queue of
// results still owed by the block.
class ring_scoreboard;
    logic [HANDLE_W-1:0] handle_mem [DEPTH];
    logic [TIME_W-1:0]   stamp_mem [DEPTH];
    int unsigned         wr_slot;
    int unsigned         fill;
    int unsigned         capacity;
    logic [TIME_W-1:0]   newest_stamp;
    bit                  stamp_seen;
    logic [TIME_W-1:0]   age_limit;
    out_item_t           pending [$];
    int unsigned         errors;
    int unsigned         n_stored, n_stale, n_too_old;
    int unsigned         n_hits, n_misses, n_purges, n_other;

    function void clear_ring();
        wr_slot      = 0;
        fill         = 0;
        newest_stamp = '0;
        stamp_seen   = 1'b0;
    endfunction

    function void power_on();
        capacity  = DEPTH;
        age_limit = '0;
        clear_ring();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        if (idx == CFG_CAPACITY) begin
            if (value == 0)
                capacity = 1;
            else if (value > DEPTH)
                capacity = DEPTH;
            else
                capacity = 32'(value);
            clear_ring();
        end else if (idx == CFG_MAX_AGE) begin
            age_limit = value;
        end
    endfunction

    function bit expired(logic [TIME_W-1:0] stamp, logic [TIME_W-1:0] now);
        return age_limit != 0 && now > stamp && (now - stamp) > age_limit;
    endfunction

    // slot lying back places behind the write slot
    function int unsigned slot_back(int unsigned back);
        return (wr_slot + capacity - back) % capacity;
    endfunction

    function void drop_expired(logic [TIME_W-1:0] now);
        if (age_limit == 0)
            return;
        while (fill > 0 && expired(stamp_mem[slot_back(fill)], now))
            fill--;
    endfunction

    function void note_input(in_item_t it);
        out_item_t   exp_r;
        int unsigned s;
        exp_r        = '0;
        exp_r.status = ST_OK;
        case (it.cmd)
            CMD_ADD: begin
                if (stamp_seen && !(it.item_time > newest_stamp)) begin
                    exp_r.status = ST_NOT_INC;
                    n_stale++;
                end else if (expired(it.item_time, it.current_time)) begin
                    exp_r.status = ST_TOO_OLD;
                    n_too_old++;
                end else begin
                    handle_mem[wr_slot] = it.payload_handle;
                    stamp_mem[wr_slot]  = it.item_time;
                    newest_stamp        = it.item_time;
                    stamp_seen          = 1'b1;
                    wr_slot             = (wr_slot + 1) % capacity;
                    if (fill < capacity)
                        fill++;
                    drop_expired(it.current_time);
                    n_stored++;
                end
            end
            CMD_READ: begin
                if (it.age_index >= fill) begin
                    exp_r.status = ST_NO_ENTRY;
                end else begin
                    s = slot_back(it.age_index + 1);
                    if (expired(stamp_mem[s], it.current_time))
                        exp_r.status = ST_NO_ENTRY;
                    else
                        exp_r.payload_out = handle_mem[s];
                end
                if (exp_r.status == ST_OK)
                    n_hits++;
                else
                    n_misses++;
            end
            CMD_PURGE: begin
                drop_expired(it.current_time);
                n_purges++;
            end
            default: begin
                n_other++;
            end
        endcase
        exp_r.stored_count = CNT_W'(fill);
        pending.push_back(exp_r);
    endfunction

    function void check_result(out_item_t got);
        out_item_t want;
        if (pending.size() == 0) begin
            $error("result with no item outstanding: status %0d payload_out %0h count %0d",
                   got.status, got.payload_out, got.stored_count);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
        end
        if (got.payload_out !== want.payload_out) begin
            $error("payload_out: expected %0h, actual %0h", want.payload_out, got.payload_out);
            errors++;
        end
        if (got.stored_count !== want.stored_count) begin
            $error("stored_count: expected %0d, actual %0d", want.stored_count,
                   got.stored_count);
            errors++;
        end
    endfunction
endclass

module timestamped_ring_buffer_with_expiry_top_tb;

    localparam logic [CMD_W-1:0]  CMD_UNUSED    = 2'd3;
    localparam logic [TIME_W-1:0] TMAX          = '1;
    localparam int unsigned       STALL_LIMIT   = 2000;
    localparam int unsigned       SETTLE_CYCLES = 8;
    localparam int unsigned       PHASES        = 8;
    localparam int unsigned       PHASE_ITEMS   = 100;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_item_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_item_t            m_data;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    ring_scoreboard       sb;
    bit                   calm = 1'b0;     // no idling on either side while set
    logic [TIME_W-1:0]    phase_base;      // time origin until the first stored add
    int unsigned          n_settings = 0;

    timestamped_ring_buffer_with_expiry_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Check every result taken at an edge against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1)
            sb.check_result(m_data);
    end

    // Stall the result side in random bursts; cut a burst short and keep
    // ready high once calm.
    initial begin
        int unsigned gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
            if (!calm) begin
                m_ready <= 1'b0;
                gap = $urandom_range(1, 18);
                while (gap != 0 && !calm) begin
                    @(posedge aclk);
                    gap--;
                end
            end
        end
    end

    // End the run when no handshake completes for too long.
    initial begin
        int unsigned idle_run;
        idle_run = 0;
        while (idle_run < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid === 1'b1 && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready === 1'b1))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [TIME_W-1:0] random_ticks();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // add without wrapping past the largest time
    function automatic logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a, logic [63:0] b);
        logic [63:0] total;
        total = {16'd0, a} + b;
        return (total > {16'd0, TMAX}) ? TMAX : total[TIME_W-1:0];
    endfunction

    function automatic in_item_t compose(logic [CMD_W-1:0] cmd, logic [HANDLE_W-1:0] handle,
                                         logic [TIME_W-1:0] itime, logic [TIME_W-1:0] now,
                                         logic [AGE_W-1:0] age);
        in_item_t it;
        it.cmd            = cmd;
        it.payload_handle = handle;
        it.item_time      = itime;
        it.current_time   = now;
        it.age_index      = age;
        return it;
    endfunction

    // Mostly well-formed traffic: increasing stamps with steps sized to the
    // expiry window, so entries pile up and age out. The rest is stale or
    // too-old adds, the unused command and noise.
    function automatic in_item_t next_random_item();
        in_item_t          it;
        logic [TIME_W-1:0] anchor;
        int unsigned       span;
        int unsigned       pick;
        it.cmd            = 2'($urandom);
        it.payload_handle = 16'($urandom);
        it.item_time      = random_ticks();
        it.current_time   = random_ticks();
        it.age_index      = 4'($urandom);
        anchor = sb.stamp_seen ? sb.newest_stamp : phase_base;
        span   = (sb.age_limit != 0 && sb.age_limit < 100000) ? 32'(sb.age_limit) : 1000;
        pick   = $urandom_range(0, 99);
        if (pick < 50) begin
            it.cmd          = CMD_ADD;
            it.item_time    = sat_add(anchor, 1 + $urandom_range(0, span / 4));
            it.current_time = sat_add(it.item_time, $urandom_range(0, span / 2));
        end else if (pick < 65) begin
            it.cmd = CMD_READ;
            if (sb.fill != 0 && $urandom_range(0, 3) != 0)
                it.age_index = 4'($urandom_range(0, sb.fill - 1));
            it.current_time = sat_add(anchor, $urandom_range(0, 2 * span));
        end else if (pick < 74) begin
            it.cmd          = CMD_PURGE;
            it.current_time = sat_add(anchor, $urandom_range(0, 2 * span));
        end else if (pick < 84) begin
            // stamp not later than the newest one
            it.cmd          = CMD_ADD;
            it.item_time    = anchor - $urandom_range(0, anchor < 50 ? 32'(anchor) : 50);
            it.current_time = sat_add(anchor, $urandom_range(0, span));
        end else if (pick < 92) begin
            // stamp already past the expiry window
            it.cmd          = CMD_ADD;
            it.item_time    = sat_add(anchor, 1 + $urandom_range(0, span / 4));
            it.current_time = sat_add(it.item_time,
                                      {16'd0, sb.age_limit} + 1 + $urandom_range(0, 100));
        end else if (pick < 96) begin
            it.cmd = CMD_UNUSED;
        end else if (it.cmd == CMD_ADD) begin
            // keep noise adds from pushing the stamp to the end of time
            it.item_time = sat_add(anchor, $urandom_range(0, 65535));
        end
        return it;
    endfunction

    // Offer one item, hold it until taken, note it, then maybe idle.
    task automatic issue(in_item_t it);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_input(it);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    // Hold off the sender until every owed result is back, then let the
    // block settle.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.set_reg(idx, value);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Drain, then load both registers.
    task automatic configure(logic [CFG_W-1:0] cap, logic [CFG_W-1:0] age);
        drain_results();
        write_reg(CFG_CAPACITY, cap);
        write_reg(CFG_MAX_AGE, age);
        n_settings++;
    endtask

    task automatic run_phase(int unsigned count, bit pause_midway);
        for (int unsigned k = 0; k < count; k++) begin
            if (pause_midway && k == count / 2)
                drain_results();
            issue(next_random_item());
        end
    endtask

    initial begin
        logic [CFG_W-1:0] cap;
        logic [CFG_W-1:0] age;

        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        aresetn   <= 1'b0;
        sb = new;
        sb.power_on();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: full ring, expiry off. Read and purge on an empty
        // ring, the unused command, a first add at time zero, a repeated
        // stamp, and reads past the count.
        issue(compose(CMD_READ, 16'h0000, '0, '0, 4'd0));
        issue(compose(CMD_PURGE, 16'h0000, '0, '0, 4'd0));
        issue(compose(CMD_UNUSED, 16'hFFFF, TMAX, TMAX, 4'd15));
        issue(compose(CMD_ADD, 16'h0000, '0, '0, 4'd0));
        issue(compose(CMD_ADD, 16'h1234, '0, '0, 4'd0));
        issue(compose(CMD_ADD, 16'hFFFF, 48'd5, TMAX, 4'd0));
        issue(compose(CMD_READ, 16'h0000, '0, TMAX, 4'd0));
        issue(compose(CMD_READ, 16'h0000, '0, TMAX, 4'd1));
        issue(compose(CMD_READ, 16'h0000, '0, TMAX, 4'd2));
        issue(compose(CMD_READ, 16'h0000, '0, TMAX, 4'd15));

        // Capacity zero is taken as one: overwrite, read of an expired
        // entry, stale and too-old adds, purge down to empty.
        configure(48'd0, 48'd10);
        issue(compose(CMD_ADD, 16'hA5A5, 48'd100, 48'd100, 4'd0));
        issue(compose(CMD_ADD, 16'h5A5A, 48'd101, 48'd105, 4'd0));
        issue(compose(CMD_READ, 16'h0000, '0, 48'd200, 4'd0));
        issue(compose(CMD_ADD, 16'h0001, 48'd50, 48'd200, 4'd0));
        issue(compose(CMD_ADD, 16'h0002, 48'd102, 48'd200, 4'd0));
        issue(compose(CMD_PURGE, 16'h0000, '0, 48'd200, 4'd0));

        // Capacity above the ring is taken as full; largest age and times.
        configure(48'd31, TMAX);
        issue(compose(CMD_ADD, 16'h8001, TMAX - 1, '0, 4'd0));
        issue(compose(CMD_ADD, 16'h7FFE, TMAX, TMAX, 4'd0));
        issue(compose(CMD_READ, 16'h0000, '0, TMAX, 4'd1));
        issue(compose(CMD_ADD, 16'h0003, TMAX, TMAX, 4'd0));

        // Smallest age: a stamp ahead of the present counts as age zero,
        // then wrap a ring of three and prune on add.
        configure(48'd3, 48'd1);
        issue(compose(CMD_ADD, 16'h0020, 48'd20, 48'd5, 4'd0));
        issue(compose(CMD_ADD, 16'h0021, 48'd21, 48'd21, 4'd0));
        issue(compose(CMD_ADD, 16'h0022, 48'd22, 48'd22, 4'd0));
        issue(compose(CMD_ADD, 16'h0023, 48'd23, 48'd23, 4'd0));
        issue(compose(CMD_READ, 16'h0000, '0, 48'd23, 4'd1));

        // Random phases, each under a fresh setting; the last one runs
        // with no idling on either side.
        for (int unsigned p = 0; p < PHASES; p++) begin
            case (p)
                0, PHASES - 1: cap = 48'd16;
                1:             cap = 48'd1;
                default: begin
                    case ($urandom_range(0, 5))
                        0:       cap = 48'd0;
                        1:       cap = 48'd31;
                        default: cap = $urandom_range(1, 16);
                    endcase
                end
            endcase
            case (p)
                0:          age = '0;
                1:          age = $urandom_range(1, 50);
                2:          age = TMAX;
                PHASES - 1: age = $urandom_range(1, 5000);
                default: begin
                    case ($urandom_range(0, 4))
                        0:       age = '0;
                        1:       age = random_ticks();
                        default: age = $urandom_range(1, 5000);
                    endcase
                end
            endcase
            calm = (p == PHASES - 1);
            configure(cap, age);
            phase_base = random_ticks() >> (1 + $urandom_range(0, 30));
            run_phase(PHASE_ITEMS, p == 2 || p == 5);
        end

        // Drop valid, collect the last results, and watch for strays.
        drain_results();
        repeat (40) @(posedge aclk);

        $display("covered %0d items under %0d register settings; adds: %0d stored, %0d stale, %0d too old",
                 sb.n_stored + sb.n_stale + sb.n_too_old + sb.n_hits + sb.n_misses
                 + sb.n_purges + sb.n_other, n_settings + 1, sb.n_stored, sb.n_stale,
                 sb.n_too_old);
        $display("reads: %0d returned, %0d without entry; purges: %0d; unused commands: %0d",
                 sb.n_hits, sb.n_misses, sb.n_purges, sb.n_other);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
